### src/airspeed_from_diff_pressure_macros.svh
// ----------------------------------------------------------------------------
// Airspeed block assertion macros
// Concurrent property shorthands, reset disables both forms.
// ----------------------------------------------------------------------------
`ifndef AIRSPEED_FROM_DIFF_PRESSURE_MACROS_SVH
`define AIRSPEED_FROM_DIFF_PRESSURE_MACROS_SVH

// same-cycle implication
`define AFDP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/afdp_pkg.sv
// ----------------------------------------------------------------------------
// Airspeed package
// Widths, constants, codes and shared types of the airspeed block.
// ----------------------------------------------------------------------------
package afdp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned PRESS_W   = 22;
  localparam int unsigned DIFF_W    = PRESS_W + 1;
  localparam int unsigned PDIFF_W   = 24;
  localparam int unsigned PROD_W    = DIFF_W + GAIN_W;
  localparam int unsigned FILT_SH   = 16;
  localparam int unsigned RAD_LSB   = 4;
  localparam int unsigned ROOT_W    = 17;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SCALE_W   = 31;
  localparam int unsigned SCALE_SH  = 8;
  localparam int unsigned MCNT_W    = $clog2(GAIN_W);
  localparam int unsigned SCNT_W    = $clog2(ROOT_W);

  localparam logic [PDIFF_W-1:0] P_BASE   = 24'd2206322;
  localparam logic [16:0]        P_SCALE  = 17'd68952;
  localparam logic [PROD_W-1:0]  P_ROUND  = PROD_W'(32768);

  localparam logic [CFG_W-1:0] FILTER_GAIN_RST      = 16'd7209;
  localparam logic [CFG_W-1:0] TWO_OVER_DENSITY_RST = 16'd6687;
  localparam logic [CFG_W-1:0] SPEED_OFFSET_RST     = 16'd512;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_OVER_DENSITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_OFFSET     = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 2'd0,
    ST_CAL     = 2'd1,
    ST_INVALID = 2'd2
  } afdp_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MULF,
    S_FUPD,
    S_DCHK,
    S_MULS,
    S_SQRT,
    S_EMIT
  } afdp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } afdp_unit_st_t;

endpackage

### src/afdp_if.sv
// ----------------------------------------------------------------------------
// Airspeed channels
// Sensor frame input channel and airspeed result channel.
// ----------------------------------------------------------------------------
interface afdp_in_if import afdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_high;
  logic [BYTE_W-1:0] frame_low;

  modport source (output valid, output frame_high, output frame_low, input ready);
  modport sink   (input valid, input frame_high, input frame_low, output ready);
endinterface

interface afdp_out_if import afdp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SPEED_W-1:0]        speed;
  logic signed [PDIFF_W-1:0] pressure_diff;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output speed, output pressure_diff, output status,
                  input ready);
  modport sink   (input valid, input speed, input pressure_diff, input status,
                  output ready);
endinterface

### src/afdp_mul.sv
// ----------------------------------------------------------------------------
// Airspeed serial multiplier
// Signed by unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module afdp_mul import afdp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] mcand_i,
  input  logic [GAIN_W-1:0]        mplier_i,
  output logic [PROD_W-1:0]        prod_o,
  output afdp_unit_st_t            st_o
);

  logic [PROD_W-1:0] mcand_q;
  logic [PROD_W-1:0] acc_q;
  logic [GAIN_W-1:0] mplier_q;
  logic [MCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q  <= '0;
      acc_q    <= '0;
      mplier_q <= '0;
      cnt_q    <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else if (start_i) begin
      mcand_q  <= {{GAIN_W{mcand_i[DIFF_W-1]}}, mcand_i};
      acc_q    <= '0;
      mplier_q <= mplier_i;
      cnt_q    <= '0;
      busy_q   <= 1'b1;
      done_q   <= 1'b0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      cnt_q    <= cnt_q + MCNT_W'(1);
      if (cnt_q == MCNT_W'(GAIN_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign prod_o  = acc_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

### src/afdp_sqrt.sv
// ----------------------------------------------------------------------------
// Airspeed serial square root
// Restoring floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module afdp_sqrt import afdp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o,
  output afdp_unit_st_t     st_o
);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], fits};
      cnt_q  <= cnt_q + SCNT_W'(1);
      if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign root_o    = root_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

### src/airspeed_from_diff_pressure.sv
// ----------------------------------------------------------------------------
// Airspeed from differential pressure
// Converts sensor frames to pressure, calibrates a zero offset, low-pass
// filters the pressure and derives airspeed through a serial square root.
//
//   channel  dir  handshake            payload
//   in_i     in   valid/ready          frame_high[8], frame_low[8]
//   out_o    out  valid/ready          speed[16], pressure_diff[24], status[2]
//   cfg      in   cfg_we_i (no wait)   cfg_idx_i[2], cfg_data_i[16]
//
// Invalid or calibrating transaction: checked, then emitted directly.
// Last calibration transaction: also runs the serial offset divider.
// Filtered transaction: one serial multiplier pass below the speed threshold,
// else two passes and the serial square root.
// Reset restores register defaults and restarts calibration.
// A result waits in the output register; the next transaction is accepted
// meanwhile and holds in its final state until the register frees.
// ----------------------------------------------------------------------------
`include "airspeed_from_diff_pressure_macros.svh"

module airspeed_from_diff_pressure import afdp_pkg::*; #(
  parameter int unsigned CAL_SAMPLES = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  afdp_in_if.sink              in_i,
  afdp_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CntW    = $clog2(CAL_SAMPLES + 1);
  localparam int unsigned SumW    = PRESS_W + CntW;
  localparam int unsigned DivCntW = $clog2(SumW);
  localparam logic [CntW-1:0] CalLast = CntW'(CAL_SAMPLES);
  localparam logic [CntW:0]   CalDiv  = (CntW + 1)'(CAL_SAMPLES);
  localparam logic [SumW-1:0] CalHalf = SumW'(CAL_SAMPLES / 2);

  afdp_state_e state_q, state_d;

  logic [BYTE_W-1:0]  frame_hi_q, frame_hi_d;
  logic [BYTE_W-1:0]  frame_lo_q, frame_lo_d;
  logic [CFG_W-1:0]   gain_q, gain_d;
  logic [CFG_W-1:0]   tod_q, tod_d;
  logic [CFG_W-1:0]   spd_off_q, spd_off_d;
  logic               calibrating_q, calibrating_d;
  logic [CntW-1:0]    cal_cnt_q, cal_cnt_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SumW-1:0]    div_q, div_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [PRESS_W-1:0] zero_off_q, zero_off_d;
  logic [PRESS_W-1:0] filt_q, filt_d;
  logic [SPEED_W-1:0] last_speed_q, last_speed_d;
  logic [PDIFF_W-1:0] last_press_q, last_press_d;
  afdp_status_e       res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [SPEED_W-1:0] out_speed_q, out_speed_d;
  logic [PDIFF_W-1:0] out_press_q, out_press_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic [COUNT_W-1:0] count;
  logic [SCALE_W-1:0] scaled;
  logic [PDIFF_W-1:0] press_s;
  logic [PRESS_W-1:0] press;
  logic               frame_ok;
  logic [PDIFF_W-1:0] press_rel;
  logic [SumW-1:0]    sum_new;
  logic [CntW-1:0]    cal_cnt_inc;
  logic [CntW:0]      div_rem_sh;
  logic               div_fits;
  logic [SumW-1:0]    div_next;
  logic [PROD_W-1:0]  prod_rnd;
  logic [DIFF_W-1:0]  filt_step;
  logic [PDIFF_W-1:0] filt_sum;
  logic [DIFF_W-1:0]  press_dev;
  logic [DIFF_W-1:0]  speed_arg;
  logic [PDIFF_W-1:0] speed_thr;
  logic [ROOT_W-1:0]  root_rel;
  logic [SPEED_W-1:0] speed_new;

  logic               mul_start;
  logic [DIFF_W-1:0]  mul_mcand;
  logic [GAIN_W-1:0]  mul_mplier;
  logic [PROD_W-1:0]  mul_prod;
  afdp_unit_st_t      mul_st;
  logic               sqrt_start;
  logic [ROOT_W-1:0]  sqrt_root;
  afdp_unit_st_t      sqrt_st;

  // frame decode and pressure conversion
  assign count     = {frame_hi_q[COUNT_W-BYTE_W-1:0], frame_lo_q};
  assign scaled    = SCALE_W'(count) * SCALE_W'(P_SCALE);
  assign press_s   = P_BASE - {1'b0, scaled[SCALE_W-1:SCALE_SH]};
  assign press     = press_s[PRESS_W-1:0];
  assign frame_ok  = (frame_hi_q[BYTE_W-1:BYTE_W-2] == 2'b00) && (count != '0) &&
                     !press_s[PDIFF_W-1];
  assign press_rel = {2'b00, press} - {2'b00, zero_off_q};

  // calibration accumulate and serial offset divide
  assign sum_new     = sum_q + SumW'(press);
  assign cal_cnt_inc = cal_cnt_q + CntW'(1);
  assign div_rem_sh  = {rem_q, div_q[SumW-1]};
  assign div_fits    = div_rem_sh >= CalDiv;
  assign div_next    = {div_q[SumW-2:0], div_fits};

  // filter update
  assign press_dev = {1'b0, press} - {1'b0, filt_q};
  assign prod_rnd  = mul_prod + P_ROUND;
  assign filt_step = prod_rnd[PROD_W-1:FILT_SH];
  assign filt_sum  = {2'b00, filt_q} + {filt_step[DIFF_W-1], filt_step};

  // airspeed
  assign speed_arg = {1'b0, filt_q} - {1'b0, zero_off_q};
  assign speed_thr = {speed_arg[DIFF_W-1], speed_arg} - {{(PDIFF_W-CFG_W){1'b0}}, spd_off_q};
  assign root_rel  = sqrt_root - {1'b0, spd_off_q};
  always_comb begin
    if (sqrt_root < {1'b0, spd_off_q}) begin
      speed_new = '0;
    end else if (root_rel[ROOT_W-1]) begin
      speed_new = '1;
    end else begin
      speed_new = root_rel[SPEED_W-1:0];
    end
  end

  assign mul_mcand  = (state_q == S_CHECK) ? press_dev : speed_arg;
  assign mul_mplier = (state_q == S_CHECK) ? gain_q : tod_q;

  afdp_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .prod_o   (mul_prod),
    .st_o     (mul_st)
  );

  afdp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (mul_prod[RAD_LSB +: RAD_W]),
    .root_o  (sqrt_root),
    .st_o    (sqrt_st)
  );

  always_comb begin
    state_d       = state_q;
    frame_hi_d    = frame_hi_q;
    frame_lo_d    = frame_lo_q;
    gain_d        = gain_q;
    tod_d         = tod_q;
    spd_off_d     = spd_off_q;
    calibrating_d = calibrating_q;
    cal_cnt_d     = cal_cnt_q;
    sum_d         = sum_q;
    div_d         = div_q;
    rem_d         = rem_q;
    dcnt_d        = dcnt_q;
    zero_off_d    = zero_off_q;
    filt_d        = filt_q;
    last_speed_d  = last_speed_q;
    last_press_d  = last_press_q;
    res_status_d  = res_status_q;
    out_valid_d   = out_valid_q;
    out_speed_d   = out_speed_q;
    out_press_d   = out_press_q;
    out_status_d  = out_status_q;
    mul_start     = 1'b0;
    sqrt_start    = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_GAIN:      gain_d    = cfg_data_i;
        CFG_TWO_OVER_DENSITY: tod_d     = cfg_data_i;
        CFG_SPEED_OFFSET:     spd_off_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          frame_hi_d = in_i.frame_high;
          frame_lo_d = in_i.frame_low;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!frame_ok) begin
          res_status_d = ST_INVALID;
          state_d      = S_EMIT;
        end else if (calibrating_q) begin
          sum_d        = sum_new;
          last_press_d = press_rel;
          cal_cnt_d    = cal_cnt_inc;
          res_status_d = ST_CAL;
          if (cal_cnt_inc == CalLast) begin
            div_d   = sum_new + CalHalf;
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_EMIT;
          end
        end else begin
          last_press_d = press_rel;
          res_status_d = ST_UPDATED;
          mul_start    = 1'b1;
          state_d      = S_MULF;
        end
      end
      S_DIV: begin
        div_d  = div_next;
        rem_d  = div_fits ? CntW'(div_rem_sh - CalDiv) : div_rem_sh[CntW-1:0];
        dcnt_d = dcnt_q + DivCntW'(1);
        if (dcnt_q == DivCntW'(SumW - 1)) begin
          zero_off_d    = div_next[PRESS_W-1:0];
          filt_d        = '0;
          calibrating_d = 1'b0;
          state_d       = S_EMIT;
        end
      end
      S_MULF: begin
        if (mul_st.done) begin
          state_d = S_FUPD;
        end
      end
      S_FUPD: begin
        filt_d  = filt_sum[PRESS_W-1:0];
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (speed_thr[PDIFF_W-1]) begin
          last_speed_d = '0;
          state_d      = S_EMIT;
        end else begin
          mul_start = 1'b1;
          state_d   = S_MULS;
        end
      end
      S_MULS: begin
        if (mul_st.done) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_st.done) begin
          last_speed_d = speed_new;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_speed_d  = last_speed_q;
          out_press_d  = last_press_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      frame_hi_q    <= '0;
      frame_lo_q    <= '0;
      gain_q        <= FILTER_GAIN_RST;
      tod_q         <= TWO_OVER_DENSITY_RST;
      spd_off_q     <= SPEED_OFFSET_RST;
      calibrating_q <= 1'b1;
      cal_cnt_q     <= '0;
      sum_q         <= '0;
      div_q         <= '0;
      rem_q         <= '0;
      dcnt_q        <= '0;
      zero_off_q    <= '0;
      filt_q        <= '0;
      last_speed_q  <= '0;
      last_press_q  <= '0;
      res_status_q  <= ST_UPDATED;
      out_valid_q   <= 1'b0;
      out_speed_q   <= '0;
      out_press_q   <= '0;
      out_status_q  <= '0;
    end else begin
      state_q       <= state_d;
      frame_hi_q    <= frame_hi_d;
      frame_lo_q    <= frame_lo_d;
      gain_q        <= gain_d;
      tod_q         <= tod_d;
      spd_off_q     <= spd_off_d;
      calibrating_q <= calibrating_d;
      cal_cnt_q     <= cal_cnt_d;
      sum_q         <= sum_d;
      div_q         <= div_d;
      rem_q         <= rem_d;
      dcnt_q        <= dcnt_d;
      zero_off_q    <= zero_off_d;
      filt_q        <= filt_d;
      last_speed_q  <= last_speed_d;
      last_press_q  <= last_press_d;
      res_status_q  <= res_status_d;
      out_valid_q   <= out_valid_d;
      out_speed_q   <= out_speed_d;
      out_press_q   <= out_press_d;
      out_status_q  <= out_status_d;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.speed         = out_speed_q;
  assign out_o.pressure_diff = out_press_q;
  assign out_o.status        = out_status_q;

  `AFDP_ASSERT_IMPL(a_no_mul_in_cal, clk_i, rst_ni, calibrating_q, !mul_start,
                    "multiplier started during calibration")
  `AFDP_ASSERT_IMPL(a_units_excl, clk_i, rst_ni, mul_st.busy, !sqrt_st.busy,
                    "multiplier and square root busy together")
  `AFDP_ASSERT_IMPL(a_cal_count_end, clk_i, rst_ni, !calibrating_q, cal_cnt_q == CalLast,
                    "calibration ended at wrong count")
  `AFDP_ASSERT_NEXT(a_emit_load, clk_i, rst_ni,
                    state_q == S_EMIT && (!out_valid_q || out_o.ready),
                    out_valid_q && state_q == S_IDLE,
                    "result not loaded into output register")

endmodule
